### hw/rtl/indexed_min_heap_decrease_key_macros.svh
// Assertion macros shared by the checker.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IMH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IMH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/imh_pkg.sv
`default_nettype none
package imh_pkg;
    localparam int NUM_ITEMS     = 64;
    localparam int ID_BITS       = $clog2(NUM_ITEMS);
    localparam int CNT_BITS      = $clog2(NUM_ITEMS + 1);
    localparam int PRIORITY_BITS = 32;

    typedef logic [ID_BITS-1:0]       id_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;
    typedef logic [PRIORITY_BITS-1:0] prio_t;

    localparam logic [1:0] OUT_INSERTED = 2'd0;
    localparam logic [1:0] OUT_LOWERED  = 2'd1;
    localparam logic [1:0] OUT_KEPT     = 2'd2;

    // One port of a memory: read or write at one address.
    typedef struct packed {
        logic  we;
        id_t   addr;
        logic [PRIORITY_BITS-1:0] wdata;
    } mem_req_t;
endpackage
`default_nettype wire

### hw/rtl/imh_ram.sv
`default_nettype none
module imh_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hw/rtl/imh_ctrl.sv
`default_nettype none
module imh_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_func,
    input  wire imh_pkg::id_t                 in_id,
    input  wire imh_pkg::prio_t               in_prio,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [80:0]                       res_data,
    output imh_pkg::mem_req_t                 hs_req,
    input  wire imh_pkg::id_t                 hs_rd,
    output imh_pkg::mem_req_t                 sl_req,
    input  wire imh_pkg::id_t                 sl_rd,
    output imh_pkg::mem_req_t                 pr_req,
    input  wire imh_pkg::prio_t               pr_rd
);
    // Each memory access: issue, then the data lands in the next state (e.g. PUSHW).
    typedef enum logic [14:0] {
        S_IDLE = 15'd1,     S_PUSH = 15'd2,    S_PUSHW = 15'd4,
        S_UPA  = 15'd8,     S_UPB  = 15'd16,   S_UPC  = 15'd32,
        S_UPD  = 15'd64,    S_POP0 = 15'd128,  S_POP1 = 15'd256,
        S_DNA  = 15'd512,   S_DNB  = 15'd1024, S_DNC  = 15'd2048,
        S_DND  = 15'd4096,  S_HEAD = 15'd8192, S_OUT  = 15'd16384
    } st_t;

    st_t st_reg, st_next;
    logic [imh_pkg::NUM_ITEMS-1:0] pres_reg, pres_next;
    imh_pkg::cnt_t cnt_reg, cnt_next;
    imh_pkg::id_t id_reg, id_next;
    imh_pkg::prio_t prio_reg, prio_next;
    // Item being sifted: its id, slot and key.
    imh_pkg::id_t cur_reg, cur_next;
    imh_pkg::cnt_t pos_reg, pos_next;
    imh_pkg::prio_t key_reg, key_next;
    // Candidate partner (parent or chosen child).
    imh_pkg::id_t oid_reg, oid_next;
    imh_pkg::prio_t okey_reg, okey_next;
    logic [2:0] sub_reg, sub_next;
    logic err_reg, err_next;
    logic [1:0] outc_reg, outc_next;
    imh_pkg::id_t pid_reg, pid_next;
    imh_pkg::prio_t pprio_reg, pprio_next;
    imh_pkg::prio_t head_reg, head_next;
    logic rv_reg, rv_next;
    imh_pkg::id_t lid_reg, lid_next;
    // Result held for the receiver, apart from the working registers.
    logic [80:0] res_reg, res_next;

    imh_pkg::cnt_t lch, rch, par;
    assign lch = imh_pkg::CNT_BITS'({pos_reg, 1'b1});
    assign rch = lch + imh_pkg::cnt_t'(1);
    assign par = (pos_reg - imh_pkg::cnt_t'(1)) >> 1;

    assign in_ready  = (st_reg == S_IDLE);
    assign res_valid = rv_reg;
    assign res_data  = res_reg;

    always_comb begin
        st_next = st_reg; pres_next = pres_reg; cnt_next = cnt_reg;
        id_next = id_reg; prio_next = prio_reg;
        cur_next = cur_reg; pos_next = pos_reg; key_next = key_reg;
        oid_next = oid_reg; okey_next = okey_reg; sub_next = sub_reg;
        err_next = err_reg; outc_next = outc_reg; pid_next = pid_reg;
        pprio_next = pprio_reg; head_next = head_reg; rv_next = rv_reg;
        lid_next = lid_reg; res_next = res_reg;
        hs_req = '0; sl_req = '0; pr_req = '0;
        if (rv_reg && res_ready) begin
            rv_next = 1'b0;
        end
        case (st_reg)
            S_IDLE: begin
                if (in_valid) begin
                    id_next = in_id; prio_next = in_prio;
                    err_next = 1'b0; outc_next = imh_pkg::OUT_INSERTED;
                    pid_next = '0; pprio_next = '0;
                    st_next = in_func ? S_POP0 : S_PUSH;
                end
            end
            S_PUSH: begin
                sl_req.addr = id_reg; pr_req.addr = id_reg;
                st_next = S_PUSHW;
            end
            S_PUSHW: begin
                cur_next = id_reg; key_next = prio_reg;
                if (pres_reg[id_reg]) begin
                    if (prio_reg < pr_rd) begin
                        outc_next = imh_pkg::OUT_LOWERED;
                        pr_req = '{1'b1, id_reg, prio_reg};
                        pos_next = imh_pkg::cnt_t'(sl_rd);
                        st_next = S_UPA;
                    end else begin
                        outc_next = imh_pkg::OUT_KEPT;
                        st_next = S_HEAD;
                    end
                end else if (cnt_reg >= imh_pkg::cnt_t'(imh_pkg::NUM_ITEMS)) begin
                    outc_next = imh_pkg::OUT_KEPT;
                    st_next = S_HEAD;
                end else begin
                    pr_req = '{1'b1, id_reg, prio_reg};
                    pres_next[id_reg] = 1'b1;
                    pos_next = cnt_reg;
                    cnt_next = cnt_reg + imh_pkg::cnt_t'(1);
                    st_next = S_UPA;
                end
            end
            // Sift up: cur item at pos; fetch parent id, then parent key.
            S_UPA: begin
                if (pos_reg == '0) begin
                    hs_req = '{1'b1, '0, 32'(cur_reg)};
                    sl_req = '{1'b1, cur_reg, '0};
                    st_next = S_HEAD;
                end else begin
                    hs_req.addr = imh_pkg::ID_BITS'(par);
                    st_next = S_UPB;
                end
            end
            S_UPB: begin
                oid_next = hs_rd; pr_req.addr = hs_rd;
                st_next = S_UPC;
            end
            S_UPC: begin
                if (key_reg < pr_rd) begin
                    hs_req = '{1'b1, imh_pkg::ID_BITS'(pos_reg), 32'(oid_reg)};
                    sl_req = '{1'b1, oid_reg, 32'(pos_reg)};
                    pos_next = par;
                    st_next = S_UPA;
                end else begin
                    hs_req = '{1'b1, imh_pkg::ID_BITS'(pos_reg), 32'(cur_reg)};
                    sl_req = '{1'b1, cur_reg, 32'(pos_reg)};
                    st_next = S_HEAD;
                end
            end
            S_POP0: begin
                if (cnt_reg == '0) begin
                    err_next = 1'b1;
                    st_next = S_OUT;
                end else begin
                    hs_req.addr = '0; sub_next = '0;
                    st_next = S_POP1;
                end
            end
            // Fetch root id, root key, last id, last key over several beats.
            S_POP1: begin
                sub_next = sub_reg + 3'd1;
                case (sub_reg)
                    3'd0: begin
                        pid_next = hs_rd; pr_req.addr = hs_rd;
                        hs_req.addr = imh_pkg::ID_BITS'(cnt_reg - imh_pkg::cnt_t'(1));
                    end
                    3'd1: begin
                        pprio_next = pr_rd; cur_next = hs_rd; pr_req.addr = hs_rd;
                    end
                    default: begin
                        key_next = pr_rd; pos_next = '0;
                        pres_next[pid_reg] = 1'b0;
                        cnt_next = cnt_reg - imh_pkg::cnt_t'(1);
                        st_next = (cnt_reg == imh_pkg::cnt_t'(1)) ? S_HEAD : S_DNA;
                    end
                endcase
            end
            // Sift down: read left child id/key, right child id/key, pick.
            S_DNA: begin
                if (lch >= cnt_reg) begin
                    hs_req = '{1'b1, imh_pkg::ID_BITS'(pos_reg), 32'(cur_reg)};
                    sl_req = '{1'b1, cur_reg, 32'(pos_reg)};
                    st_next = S_HEAD;
                end else begin
                    hs_req.addr = imh_pkg::ID_BITS'(lch); sub_next = '0;
                    st_next = S_DNB;
                end
            end
            S_DNB: begin
                sub_next = sub_reg + 3'd1;
                case (sub_reg)
                    3'd0: begin
                        oid_next = hs_rd; pr_req.addr = hs_rd;
                        if (rch < cnt_reg) begin
                            hs_req.addr = imh_pkg::ID_BITS'(rch);
                        end
                    end
                    3'd1: begin
                        okey_next = pr_rd;
                        if (rch < cnt_reg) begin
                            lid_next = hs_rd; pr_req.addr = hs_rd;
                        end else begin
                            st_next = S_DNC;
                        end
                    end
                    default: begin
                        if (pr_rd < okey_reg) begin
                            okey_next = pr_rd; oid_next = lid_reg;
                            pos_next = pos_reg;
                            sub_next = 3'd7;
                        end
                        st_next = S_DNC;
                    end
                endcase
            end
            S_DNC: begin
                if (okey_reg < key_reg) begin
                    hs_req = '{1'b1, imh_pkg::ID_BITS'(pos_reg), 32'(oid_reg)};
                    sl_req = '{1'b1, oid_reg, 32'(pos_reg)};
                    pos_next = (sub_reg == 3'd7) ? rch : lch;
                    st_next = S_DNA;
                end else begin
                    hs_req = '{1'b1, imh_pkg::ID_BITS'(pos_reg), 32'(cur_reg)};
                    sl_req = '{1'b1, cur_reg, 32'(pos_reg)};
                    st_next = S_HEAD;
                end
            end
            S_HEAD: begin
                hs_req.addr = '0; st_next = S_UPD;
            end
            S_UPD: begin
                pr_req.addr = hs_rd; st_next = S_DND;
            end
            S_DND: begin
                head_next = (cnt_reg != '0) ? pr_rd : '0;
                st_next = S_OUT;
            end
            S_OUT: begin
                if (!rv_reg || res_ready) begin
                    if (err_reg) begin
                        head_next = (cnt_reg != '0) ? head_reg : '0;
                    end
                    res_next = {cnt_reg, head_reg, cnt_reg != '0, pprio_reg, pid_reg,
                                outc_reg, err_reg};
                    rv_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; pres_reg <= '0; cnt_reg <= '0; rv_reg <= 1'b0;
            head_reg <= '0;
        end else begin
            st_reg <= st_next; pres_reg <= pres_next; cnt_reg <= cnt_next;
            rv_reg <= rv_next; head_reg <= head_next;
        end
        id_reg <= id_next; prio_reg <= prio_next;
        cur_reg <= cur_next; pos_reg <= pos_next; key_reg <= key_next;
        oid_reg <= oid_next; okey_reg <= okey_next; sub_reg <= sub_next;
        err_reg <= err_next; outc_reg <= outc_next; pid_reg <= pid_next;
        pprio_reg <= pprio_next; lid_reg <= lid_next; res_reg <= res_next;
    end
endmodule
`default_nettype wire

### hw/rtl/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key.
// Input channel s_*: tdata = {new_priority[37:6], item_id[5:0]} (40 bits),
// tuser = func (0 push or lower key, 1 pop minimum).
// Result channel m_*: tdata from bit 0 up: error, push_outcome(2), popped_id(6),
// popped_priority(32), head_valid, head_priority(32), entry_total(7), padded.
// One item is handled at a time. Heap slots, slot per id and priority per id
// live in three single-port synchronous RAMs. A sift-up level reads the parent
// id, then the parent key; a sift-down level reads the left child id and key
// and, where present, the right child id and key. Every operation but the pop
// of an empty heap ends with a lookup of the head. The next beat is taken once
// the result has gone into the output register, so the input takes no new beat
// while an item is being handled, whatever the depth of its sift.
// Reset empties the heap at once through the per-id presence flags and the
// count; the RAM contents are never cleared and are only used once written.
// The result sits in an output register and is held unchanged while the
// receiver stalls. The next beat may be taken meanwhile; its result waits until
// the register has been emptied, and no further beat is taken before that.
`default_nettype none
module indexed_min_heap_decrease_key (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // item_id[5:0], new_priority[37:6]
    input  wire logic        s_tuser,  // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // error, push_outcome, popped_id, ...
);
    imh_pkg::mem_req_t hs_req, sl_req, pr_req;
    logic [imh_pkg::ID_BITS-1:0] hs_rd, sl_rd;
    logic [imh_pkg::PRIORITY_BITS-1:0] pr_rd;
    logic [80:0] res;

    imh_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_func(s_tuser),
        .in_id(s_tdata[5:0]), .in_prio(s_tdata[37:6]),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res),
        .hs_req, .hs_rd, .sl_req, .sl_rd, .pr_req, .pr_rd
    );

    imh_ram #(.DEPTH(imh_pkg::NUM_ITEMS), .WIDTH(imh_pkg::ID_BITS)) u_heap (
        .aclk, .we(hs_req.we), .addr(hs_req.addr),
        .wdata(hs_req.wdata[imh_pkg::ID_BITS-1:0]), .rdata(hs_rd)
    );
    imh_ram #(.DEPTH(imh_pkg::NUM_ITEMS), .WIDTH(imh_pkg::ID_BITS)) u_slot (
        .aclk, .we(sl_req.we), .addr(sl_req.addr),
        .wdata(sl_req.wdata[imh_pkg::ID_BITS-1:0]), .rdata(sl_rd)
    );
    imh_ram #(.DEPTH(imh_pkg::NUM_ITEMS), .WIDTH(imh_pkg::PRIORITY_BITS)) u_prio (
        .aclk, .we(pr_req.we), .addr(pr_req.addr),
        .wdata(pr_req.wdata), .rdata(pr_rd)
    );

    assign m_tdata = {7'd0, res};
endmodule
`default_nettype wire

### hw/rtl/imh_checker.sv
`default_nettype none
`include "indexed_min_heap_decrease_key_macros.svh"
module imh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata
);
    `IMH_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `IMH_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `IMH_ASSERT_IMPL(a_head, aclk, aresetn, m_tvalid, m_tdata[41] == (m_tdata[80:74] != 7'd0))
    `IMH_ASSERT_IMPL(a_err, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[87:1] == 87'd0)
endmodule
bind indexed_min_heap_decrease_key imh_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
